@@ rtl/spg_pkg.sv @@
// Shared types and constants of the spring parameter gradient core.
// Fixed-point format, gradient range and configuration register indexes.
// No dependencies.
package spg_pkg;

   localparam int GRAD_W = 48;
   localparam int FRAC_BITS = 16;

   typedef logic signed [GRAD_W-1:0] grad_type;
   typedef logic [2*GRAD_W-1:0] entry_type;

   localparam grad_type GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
   localparam grad_type GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};
   localparam logic [GRAD_W-1:0] SAT_MAG_POS = {1'b0, {(GRAD_W-1){1'b1}}};
   localparam logic [GRAD_W-1:0] SAT_MAG_NEG = {1'b1, {(GRAD_W-1){1'b0}}};

   localparam logic CSR_STIFF_ON = 1'b0;
   localparam logic CSR_LEN_ON = 1'b1;

endpackage

@@ rtl/spring_parameter_gradient_core.sv @@
// Spring parameter gradient core: per-spring length, projection and gradient
// accumulation over one shared multiplier (plus a 2-bit one) and one shared subtractor.
// An accepted beat runs through multiply/add steps, square-root steps and a compare; a
// spring that is applied and in range then takes divide steps, the enabled gradient updates
// and a store write, and every beat ends with the output load. One item at a time.
// Reset (synchronous) clears the gradient store.
module spring_parameter_gradient_core
   import spg_pkg::*;
#(
   parameter int SPRING_COUNT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [9:0]        req_spring_index,
   input  logic signed [31:0] req_delta_x,
   input  logic signed [31:0] req_delta_y,
   input  logic signed [31:0] req_delta_z,
   input  logic signed [31:0] req_adjoint_x,
   input  logic signed [31:0] req_adjoint_y,
   input  logic signed [31:0] req_adjoint_z,
   input  logic [30:0]       req_rest_length,
   input  logic [30:0]       req_stiffness,
   input  logic              req_spring_on,
   input  logic              req_stretch_only,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [9:0]        rsp_out_index,
   output logic              rsp_applied,
   output logic signed [47:0] rsp_stiffness_gradient,
   output logic signed [47:0] rsp_length_gradient,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [0:0]        csr_index,
   input  logic [0:0]        csr_data
);

   localparam int ADDR_W = (SPRING_COUNT > 1) ? $clog2(SPRING_COUNT) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SPRING_COUNT - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_ACC   = 4'd3;
   localparam logic [3:0] S_SQRT  = 4'd4;
   localparam logic [3:0] S_CMP   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_PMUL  = 4'd7;
   localparam logic [3:0] S_PHI   = 4'd8;
   localparam logic [3:0] S_SCALE = 4'd9;
   localparam logic [3:0] S_SUM   = 4'd10;
   localparam logic [3:0] S_WRITE = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   // Control state
   logic [3:0]        state_ff, state_in;
   logic [5:0]        count_ff, count_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              stiff_on_ff, stiff_on_in;
   logic              len_on_ff, len_on_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Item payload and working registers
   logic [9:0]        idx_ff;
   logic              in_range_ff;
   logic [31:0]       dm_ff [0:2];
   logic [31:0]       am_ff [0:2];
   logic              pneg_ff [0:2];
   logic [30:0]       rest_ff, ks_ff;
   logic              on_ff, stretch_ff;
   logic [63:0]       prod_ff, prod_in;
   logic [63:0]       sumsq_ff, sumsq_in;
   logic signed [65:0] dot_ff, dot_in;
   logic [34:0]       rem_ff, rem_in;
   logic [31:0]       root_ff, root_in;
   logic [33:0]       quo_ff, quo_in;
   logic [63:0]       divd_ff, divd_in;
   logic              s_neg_ff, s_neg_in;
   logic              applied_ff, applied_in;
   logic [31:0]       e_mag_ff, e_mag_in;
   logic              e_neg_ff, e_neg_in;
   logic [65:0]       full_ff, full_in;
   logic signed [48:0] contrib_ff, contrib_in;
   logic              phase_ff, phase_in;
   grad_type          sg_ff, sg_in, lg_ff, lg_in;
   entry_type         entry_ff;
   logic [9:0]        rsp_idx_ff;
   logic              rsp_applied_ff;
   grad_type          rsp_sg_ff, rsp_lg_ff;

   // Datapath
   logic              accept;
   logic              rsp_load;
   logic [1:0]        lane;
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       mul_p;
   logic [33:0]       hi_p;
   logic [34:0]       sub_a, sub_b;
   logic [35:0]       diff;
   logic              ge;
   logic [65:0]       dot_abs;
   logic [65:0]       q_full;
   logic [65:0]       limit;
   logic [47:0]       q_sat;
   logic              c_neg;
   grad_type          base;
   logic signed [49:0] sum;
   logic [16:0]       req_idx_ext;
   logic [16:0]       cur_idx_ext;

   // Gradient store: stiffness gradient in the upper half, length gradient below.
   entry_type         mem [SPRING_COUNT];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wr_addr;
   entry_type         mem_wr_data;

   assign accept      = (state_ff == S_IDLE) && req_valid;
   assign req_stall   = (state_ff != S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_index = rsp_idx_ff;
   assign rsp_applied = rsp_applied_ff;
   assign rsp_stiffness_gradient = rsp_sg_ff;
   assign rsp_length_gradient = rsp_lg_ff;

   assign req_idx_ext = 17'(req_spring_index);
   assign cur_idx_ext = 17'(idx_ff);

   assign lane  = (count_ff < 6'd3) ? count_ff[1:0] : 2'(count_ff - 6'd3);
   assign mul_p = mul_a * mul_b;
   assign hi_p  = mul_a * quo_ff[33:32];
   assign diff  = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge    = !diff[35];
   assign dot_abs = dot_ff[65] ? 66'(-dot_ff) : dot_ff;
   assign c_neg = phase_ff ? !s_neg_ff : (e_neg_ff ^ s_neg_ff);
   assign q_full = full_ff >> FRAC_BITS;
   assign limit  = c_neg ? 66'(SAT_MAG_NEG) : 66'(SAT_MAG_POS);
   assign q_sat  = (q_full > limit) ? limit[47:0] : q_full[47:0];
   assign base   = phase_ff ? lg_ff : sg_ff;
   assign sum    = {{2{base[47]}}, base} + {contrib_ff[48], contrib_ff};
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      clr_addr_in = clr_addr_ff;
      stiff_on_in = stiff_on_ff;
      len_on_in   = len_on_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      prod_in     = prod_ff;
      sumsq_in    = sumsq_ff;
      dot_in      = dot_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      quo_in      = quo_ff;
      divd_in     = divd_ff;
      s_neg_in    = s_neg_ff;
      applied_in  = applied_ff;
      e_mag_in    = e_mag_ff;
      e_neg_in    = e_neg_ff;
      full_in     = full_ff;
      contrib_in  = contrib_ff;
      phase_in    = phase_ff;
      sg_in       = sg_ff;
      lg_in       = lg_ff;
      mul_a       = '0;
      mul_b       = '0;
      sub_a       = '0;
      sub_b       = '0;
      mem_we      = 1'b0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = '0;

      if (csr_valid) begin
         case (csr_index)
            CSR_STIFF_ON: stiff_on_in = csr_data[0];
            CSR_LEN_ON:   len_on_in = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               count_in = '0;
               sumsq_in = '0;
               dot_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            mul_a = dm_ff[lane];
            mul_b = (count_ff < 6'd3) ? dm_ff[lane] : am_ff[lane];
            prod_in = mul_p;
            state_in = S_ACC;
         end
         S_ACC: begin
            if (count_ff < 6'd3) begin
               sumsq_in = sumsq_ff + prod_ff;
            end else if (pneg_ff[lane]) begin
               dot_in = dot_ff - $signed({2'b00, prod_ff});
            end else begin
               dot_in = dot_ff + $signed({2'b00, prod_ff});
            end
            if (count_ff == 6'd5) begin
               count_in = '0;
               rem_in   = '0;
               root_in  = '0;
               state_in = S_SQRT;
            end else begin
               count_in = count_ff + 6'd1;
               state_in = S_MUL;
            end
         end
         S_SQRT: begin
            sub_a = {rem_ff[32:0], sumsq_ff[63:62]};
            sub_b = {1'b0, root_ff, 2'b01};
            rem_in = ge ? diff[34:0] : sub_a;
            root_in = {root_ff[30:0], ge};
            sumsq_in = {sumsq_ff[61:0], 2'b00};
            count_in = count_ff + 6'd1;
            if (count_ff == 6'd31) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            sub_a = 35'(root_ff);
            sub_b = 35'(rest_ff);
            e_neg_in = diff[35];
            e_mag_in = diff[35] ? 32'(-diff) : diff[31:0];
            applied_in = on_ff && (root_ff != '0) &&
                         (!stretch_ff || (!diff[35] && (diff != '0)));
            s_neg_in = dot_ff[65];
            divd_in = {dot_abs[33:0], 30'b0};
            rem_in = 35'(dot_abs[63:34]);
            count_in = '0;
            sg_in = in_range_ff ? grad_type'(entry_ff[2*GRAD_W-1:GRAD_W]) : '0;
            lg_in = in_range_ff ? grad_type'(entry_ff[GRAD_W-1:0]) : '0;
            if (on_ff && (root_ff != '0) && (!stretch_ff || (!diff[35] && (diff != '0)))
                && in_range_ff) begin
               state_in = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            sub_a = {2'b00, rem_ff[31:0], divd_ff[63]};
            sub_b = 35'(root_ff);
            rem_in = ge ? diff[34:0] : sub_a;
            quo_in = {quo_ff[32:0], ge};
            divd_in = {divd_ff[62:0], 1'b0};
            count_in = count_ff + 6'd1;
            if (count_ff == 6'd33) begin
               if (stiff_on_ff) begin
                  phase_in = 1'b0;
                  state_in = S_PMUL;
               end else if (len_on_ff) begin
                  phase_in = 1'b1;
                  state_in = S_PMUL;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_PMUL: begin
            mul_a = phase_ff ? {1'b0, ks_ff} : e_mag_ff;
            mul_b = quo_ff[31:0];
            prod_in = mul_p;
            state_in = S_PHI;
         end
         S_PHI: begin
            mul_a = phase_ff ? {1'b0, ks_ff} : e_mag_ff;
            full_in = {2'b00, prod_ff} + {hi_p, 32'b0};
            state_in = S_SCALE;
         end
         S_SCALE: begin
            contrib_in = c_neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
            state_in = S_SUM;
         end
         S_SUM: begin
            if (phase_ff) begin
               lg_in = (sum[49:47] == 3'b000 || sum[49:47] == 3'b111) ? sum[47:0] :
                       (sum[49] ? GRAD_MIN : GRAD_MAX);
               state_in = S_WRITE;
            end else begin
               sg_in = (sum[49:47] == 3'b000 || sum[49:47] == 3'b111) ? sum[47:0] :
                       (sum[49] ? GRAD_MIN : GRAD_MAX);
               phase_in = 1'b1;
               state_in = len_on_ff ? S_PMUL : S_WRITE;
            end
         end
         S_WRITE: begin
            mem_we = 1'b1;
            mem_wr_addr = cur_idx_ext[ADDR_W-1:0];
            mem_wr_data = {sg_ff, lg_ff};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         count_ff     <= '0;
         clr_addr_ff  <= '0;
         stiff_on_ff  <= 1'b1;
         len_on_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_addr_ff  <= clr_addr_in;
         stiff_on_ff  <= stiff_on_in;
         len_on_ff    <= len_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff      <= req_spring_index;
         in_range_ff <= req_idx_ext < 17'(SPRING_COUNT);
         dm_ff[0]    <= req_delta_x[31] ? 32'(-req_delta_x) : req_delta_x;
         dm_ff[1]    <= req_delta_y[31] ? 32'(-req_delta_y) : req_delta_y;
         dm_ff[2]    <= req_delta_z[31] ? 32'(-req_delta_z) : req_delta_z;
         am_ff[0]    <= req_adjoint_x[31] ? 32'(-req_adjoint_x) : req_adjoint_x;
         am_ff[1]    <= req_adjoint_y[31] ? 32'(-req_adjoint_y) : req_adjoint_y;
         am_ff[2]    <= req_adjoint_z[31] ? 32'(-req_adjoint_z) : req_adjoint_z;
         pneg_ff[0]  <= req_delta_x[31] ^ req_adjoint_x[31];
         pneg_ff[1]  <= req_delta_y[31] ^ req_adjoint_y[31];
         pneg_ff[2]  <= req_delta_z[31] ^ req_adjoint_z[31];
         rest_ff     <= req_rest_length;
         ks_ff       <= req_stiffness;
         on_ff       <= req_spring_on;
         stretch_ff  <= req_stretch_only;
      end
      prod_ff    <= prod_in;
      sumsq_ff   <= sumsq_in;
      dot_ff     <= dot_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      quo_ff     <= quo_in;
      divd_ff    <= divd_in;
      s_neg_ff   <= s_neg_in;
      applied_ff <= applied_in;
      e_mag_ff   <= e_mag_in;
      e_neg_ff   <= e_neg_in;
      full_ff    <= full_in;
      contrib_ff <= contrib_in;
      phase_ff   <= phase_in;
      sg_ff      <= sg_in;
      lg_ff      <= lg_in;
      if (rsp_load) begin
         rsp_idx_ff     <= idx_ff;
         rsp_applied_ff <= applied_ff;
         rsp_sg_ff      <= sg_ff;
         rsp_lg_ff      <= lg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (accept) begin
         entry_ff <= mem[req_idx_ext[ADDR_W-1:0]];
      end
   end

endmodule
